>>> rtl/frustum_box_clip_test_macros.svh
// Assertion helpers; expect clk and arst_n in scope.
`ifndef FRUSTUM_BOX_CLIP_TEST_MACROS_SVH
`define FRUSTUM_BOX_CLIP_TEST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FBCT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbct assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FBCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbct assertion failed");

`endif

>>> rtl/fbct_pkg.sv
package fbct_pkg;

	localparam int PLANE_COUNT = 4;
	localparam int REG_PLANES  = 4;
	localparam int CELL_COUNT  = (PLANE_COUNT < REG_PLANES) ? PLANE_COUNT : REG_PLANES;

	localparam int COORD_W    = 24;
	localparam int RAD_W      = 23;
	localparam int NORM_W     = 16;
	localparam int NORMAL_W   = 3 * NORM_W;
	localparam int DIST_W     = 32;
	localparam int PROD_W     = NORM_W + COORD_W;
	localparam int SUM_W      = 48;
	localparam int FRAC_SHIFT = 14;
	localparam int FLAGS_W    = 4;
	localparam int SEL_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE0_NORMAL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE1_NORMAL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE2_NORMAL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE3_NORMAL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIST_LOW_PAIR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIST_HIGH_PAIR  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CORNER_SELECT   = 3'd6;

	typedef struct packed {
		logic [NORMAL_W-1:0] normal;
		logic [DIST_W-1:0]   offset;
		logic [2:0]          sel;
	} plane_cfg_t;

	// Model bounds plus the verdict gathered so far along the chain.
	typedef struct packed {
		logic [2:0][COORD_W-1:0] box_min;
		logic [2:0][COORD_W-1:0] box_max;
		logic [2:0][COORD_W-1:0] center;
		logic [RAD_W-1:0]        radius;
		logic                    rotated;
		logic [CELL_COUNT-1:0]   flags;
		logic                    clipped;
	} item_t;

endpackage

>>> rtl/fbct_if.sv
interface fbct_in_if;
	logic                       valid;
	logic                       ready;
	logic signed [23:0]         box_min_x;
	logic signed [23:0]         box_min_y;
	logic signed [23:0]         box_min_z;
	logic signed [23:0]         box_max_x;
	logic signed [23:0]         box_max_y;
	logic signed [23:0]         box_max_z;
	logic signed [23:0]         center_x;
	logic signed [23:0]         center_y;
	logic signed [23:0]         center_z;
	logic [22:0]                bound_radius;
	logic                       rotated;

	modport source (
		output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		center_x, center_y, center_z, bound_radius, rotated,
		input ready
	);
	modport sink (
		input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		center_x, center_y, center_z, bound_radius, rotated,
		output ready
	);
endinterface

interface fbct_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] clip_flags;
	logic       fully_clipped;

	modport source (output valid, clip_flags, fully_clipped, input ready);
	modport sink (input valid, clip_flags, fully_clipped, output ready);
endinterface

>>> rtl/fbct_cell.sv
`include "frustum_box_clip_test_macros.svh"

module fbct_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  fbct_pkg::plane_cfg_t cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  fbct_pkg::item_t     in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output fbct_pkg::item_t     out_item
);

	logic signed [fbct_pkg::COORD_W-1:0] rej_pt [3];
	logic signed [fbct_pkg::COORD_W-1:0] acc_pt [3];
	logic signed [fbct_pkg::PROD_W-1:0]  prod_rej [3];
	logic signed [fbct_pkg::PROD_W-1:0]  prod_acc [3];

	logic signed [fbct_pkg::PROD_W-1:0]  prod_rej_s1 [3];
	logic signed [fbct_pkg::PROD_W-1:0]  prod_acc_s1 [3];
	fbct_pkg::item_t                     item_s1;
	logic                                valid_s1;

	logic signed [fbct_pkg::SUM_W-1:0]   dist_term;
	logic signed [fbct_pkg::SUM_W-1:0]   thr;
	logic signed [fbct_pkg::SUM_W-1:0]   s_rej;
	logic signed [fbct_pkg::SUM_W-1:0]   s_acc;
	logic signed [fbct_pkg::SUM_W-1:0]   rej_margin;
	logic                                rej_hit;
	logic                                acc_hit;
	fbct_pkg::item_t                     next_item;

	fbct_pkg::item_t                     item_s2;
	logic                                valid_s2;
	logic                                ready_s1;
	logic                                ready_s2;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Pick the test points; a rotated model uses its origin for both.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (in_item.rotated) begin
				rej_pt[a] = $signed(in_item.center[a]);
				acc_pt[a] = $signed(in_item.center[a]);
			end else if (cfg.sel[a]) begin
				rej_pt[a] = $signed(in_item.box_max[a]);
				acc_pt[a] = $signed(in_item.box_min[a]);
			end else begin
				rej_pt[a] = $signed(in_item.box_min[a]);
				acc_pt[a] = $signed(in_item.box_max[a]);
			end
			prod_rej[a] = $signed(cfg.normal[a*fbct_pkg::NORM_W +: fbct_pkg::NORM_W]) * rej_pt[a];
			prod_acc[a] = $signed(cfg.normal[a*fbct_pkg::NORM_W +: fbct_pkg::NORM_W]) * acc_pt[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			for (int a = 0; a < 3; a++) begin
				prod_rej_s1[a] <= prod_rej[a];
				prod_acc_s1[a] <= prod_acc[a];
			end
			item_s1 <= in_item;
		end
	end

	// Sum the products, take off the plane distance, compare against the margin.
	always_comb begin
		dist_term = fbct_pkg::SUM_W'($signed(cfg.offset)) <<< fbct_pkg::FRAC_SHIFT;
		thr = item_s1.rotated
			? $signed(fbct_pkg::SUM_W'({item_s1.radius, fbct_pkg::FRAC_SHIFT'(0)}))
			: '0;
		s_rej = fbct_pkg::SUM_W'(prod_rej_s1[0]) + fbct_pkg::SUM_W'(prod_rej_s1[1])
			+ fbct_pkg::SUM_W'(prod_rej_s1[2]) - dist_term;
		s_acc = fbct_pkg::SUM_W'(prod_acc_s1[0]) + fbct_pkg::SUM_W'(prod_acc_s1[1])
			+ fbct_pkg::SUM_W'(prod_acc_s1[2]) - dist_term;
		rej_margin = s_rej + thr;
		rej_hit = rej_margin <= 0;
		acc_hit = s_acc <= thr;

		next_item = item_s1;
		// Plane i lands in flag bit i once every cell has shifted its bit in.
		next_item.flags = (item_s1.flags >> 1)
			| (fbct_pkg::CELL_COUNT'(acc_hit) << (fbct_pkg::CELL_COUNT - 1));
		next_item.clipped = item_s1.clipped || rej_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			item_s2 <= next_item;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	`FBCT_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, valid_s1)
	`FBCT_ASSERT_NEXT(a_stall_holds_s2, valid_s2 && !out_ready, valid_s2 && $stable(item_s2))
	`FBCT_ASSERT_NEXT(a_clip_sticks, valid_s1 && ready_s2 && item_s1.clipped, item_s2.clipped)
	`FBCT_ASSERT_NOW(a_no_loss_s1, valid_s1 && !ready_s2, !ready_s1)

endmodule

>>> rtl/frustum_box_clip_test.sv
// Channel   Dir  Payload
// in_ch     in   box_min_x/y/z, box_max_x/y/z, center_x/y/z, bound_radius, rotated
// out_ch    out  clip_flags, fully_clipped
// cfg_*     in   cfg_we, cfg_idx, cfg_data (write only)
//
// One request per cycle unless a stall on out_ch has filled every stage; each result passes
// through two register stages in each plane cell (multiply, then sum and compare).
// Reset clears every stage valid bit and every configuration register.
// A stall on out_ch holds the last cell; earlier cells keep filling bubbles, so
// in_ch stays ready until every stage holds a request.
module frustum_box_clip_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fbct_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [fbct_pkg::CFG_DATA_W-1:0]     cfg_data,
	fbct_in_if.sink                             in_ch,
	fbct_out_if.source                          out_ch
);

	logic [fbct_pkg::NORMAL_W-1:0] normal_q [fbct_pkg::REG_PLANES];
	logic [fbct_pkg::DIST_W-1:0]   dist_q [fbct_pkg::REG_PLANES];
	logic [fbct_pkg::SEL_W-1:0]    corner_select_q;

	fbct_pkg::item_t chain_item  [fbct_pkg::CELL_COUNT+1];
	logic            chain_valid [fbct_pkg::CELL_COUNT+1];
	logic            chain_ready [fbct_pkg::CELL_COUNT+1];
	fbct_pkg::item_t last_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fbct_pkg::REG_PLANES; i++) begin
				normal_q[i] <= '0;
				dist_q[i]   <= '0;
			end
			corner_select_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fbct_pkg::REG_PLANE0_NORMAL: normal_q[0] <= cfg_data[fbct_pkg::NORMAL_W-1:0];
				fbct_pkg::REG_PLANE1_NORMAL: normal_q[1] <= cfg_data[fbct_pkg::NORMAL_W-1:0];
				fbct_pkg::REG_PLANE2_NORMAL: normal_q[2] <= cfg_data[fbct_pkg::NORMAL_W-1:0];
				fbct_pkg::REG_PLANE3_NORMAL: normal_q[3] <= cfg_data[fbct_pkg::NORMAL_W-1:0];
				fbct_pkg::REG_DIST_LOW_PAIR: begin
					dist_q[0] <= cfg_data[31:0];
					dist_q[1] <= cfg_data[63:32];
				end
				fbct_pkg::REG_DIST_HIGH_PAIR: begin
					dist_q[2] <= cfg_data[31:0];
					dist_q[3] <= cfg_data[63:32];
				end
				fbct_pkg::REG_CORNER_SELECT: corner_select_q <= cfg_data[fbct_pkg::SEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		chain_item[0].box_min = {in_ch.box_min_z, in_ch.box_min_y, in_ch.box_min_x};
		chain_item[0].box_max = {in_ch.box_max_z, in_ch.box_max_y, in_ch.box_max_x};
		chain_item[0].center  = {in_ch.center_z, in_ch.center_y, in_ch.center_x};
		chain_item[0].radius  = in_ch.bound_radius;
		chain_item[0].rotated = in_ch.rotated;
		chain_item[0].flags   = '0;
		chain_item[0].clipped = 1'b0;
	end

	assign chain_valid[0] = in_ch.valid;
	assign in_ch.ready    = chain_ready[0];

	for (genvar i = 0; i < fbct_pkg::CELL_COUNT; i++) begin : g_cell
		fbct_pkg::plane_cfg_t plane_cfg;

		assign plane_cfg.normal = normal_q[i];
		assign plane_cfg.offset = dist_q[i];
		assign plane_cfg.sel    = corner_select_q[3*i +: 3];

		fbct_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (plane_cfg),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_item   (chain_item[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_item  (chain_item[i+1])
		);
	end

	assign last_item = chain_item[fbct_pkg::CELL_COUNT];
	assign chain_ready[fbct_pkg::CELL_COUNT] = out_ch.ready;

	// Drop the flags of a clipped model.
	assign out_ch.valid         = chain_valid[fbct_pkg::CELL_COUNT];
	assign out_ch.fully_clipped = last_item.clipped;
	assign out_ch.clip_flags    = last_item.clipped ? '0
		: fbct_pkg::FLAGS_W'(last_item.flags);

endmodule

>>> bench/frustum_box_clip_test_tb.sv
module frustum_box_clip_test_tb;

	localparam int CMIN = -8388608;
	localparam int CMAX = 8388607;
	localparam int RMAX = 8388607;
	localparam int EDGE = -16000;
	localparam int DIR_COUNT = 23;
	localparam int SETTLE_CYCLES = 2 * fbct_pkg::CELL_COUNT + 6;
	localparam int LONG_HOLD = 200;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [2:0][fbct_pkg::COORD_W-1:0] lo;
		logic [2:0][fbct_pkg::COORD_W-1:0] hi;
		logic [2:0][fbct_pkg::COORD_W-1:0] ctr;
		logic [fbct_pkg::RAD_W-1:0]        radius;
		logic                              rotated;
	} bounds_t;

	typedef struct packed {
		logic [fbct_pkg::FLAGS_W-1:0] flags;
		logic                         clipped;
	} verdict_t;

	typedef logic [int'(fbct_pkg::REG_CORNER_SELECT):0][fbct_pkg::CFG_DATA_W-1:0] reg_set_t;

	typedef enum {SET_MATCHED, SET_SKEWED, SET_NOISE} roll_mode_t;

	typedef struct {
		int lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, c_x, c_y, c_z, radius;
		bit rotated, known;
		bit [3:0] flags;
		bit clipped;
	} dir_row_t;

	// known rows run on the reset setting (all planes zero), the rest on the axis frustum
	dir_row_t dir_rows [DIR_COUNT] = '{
		//  lo x, y, z          hi x, y, z          center x, y, z     radius rot kn flags clip
		'{CMIN, CMIN, CMIN,    CMAX, CMAX, CMAX,    0, 0, 0,           0,    0, 1, 4'h0, 1},
		'{CMAX, CMAX, CMAX,    CMAX, CMAX, CMAX,    0, 0, 0,           RMAX, 0, 1, 4'h0, 1},
		'{100, 100, 100,       -100, -100, -100,    5, 5, 5,           7,    0, 1, 4'h0, 1},
		'{0, 0, 0,             0, 0, 0,             0, 0, 0,           0,    1, 1, 4'h0, 1},
		'{0, 0, 0,             0, 0, 0,             0, 0, 0,           RMAX, 1, 1, 4'hF, 0},
		'{0, 0, 0,             0, 0, 0,             CMIN, CMIN, CMIN,  1,    1, 1, 4'hF, 0},
		'{0, 0, 0,             0, 0, 0,             CMAX, CMAX, CMAX,  0,    1, 1, 4'h0, 1},
		'{CMIN, CMIN, CMIN,    CMIN, CMIN, CMIN,    CMAX, CMAX, CMAX,  3,    0, 1, 4'h0, 1},
		'{-100, -100, -100,    100, 100, 100,       0, 0, 0,           0,    0, 0, 4'h0, 0},
		'{-20000, -10, -10,    0, 10, 10,           0, 0, 0,           0,    0, 0, 4'h0, 0},
		'{-30000, -10, -10,    -20000, 10, 10,      0, 0, 0,           0,    0, 0, 4'h0, 0},
		'{-20000, 20000, -10,  0, 30000, 10,        0, 0, 0,           0,    0, 0, 4'h0, 0},
		'{EDGE, -10, -10,      100, 10, 10,         0, 0, 0,           0,    0, 0, 4'h0, 0},
		'{-15990, -10, -10,    EDGE, 10, 10,        0, 0, 0,           0,    0, 0, 4'h0, 0},
		'{CMIN, CMIN, CMIN,    CMAX, CMAX, CMAX,    0, 0, 0,           0,    0, 0, 4'h0, 0},
		'{-10, -10, CMIN,      10, 10, CMAX,        0, 0, 0,           0,    0, 0, 4'h0, 0},
		'{0, 0, 0,             0, 0, 0,             0, 0, 0,           100,  1, 0, 4'h0, 0},
		'{0, 0, 0,             0, 0, 0,             EDGE - 50, 0, 0,   50,   1, 0, 4'h0, 0},
		'{0, 0, 0,             0, 0, 0,             EDGE - 50, 0, 0,   51,   1, 0, 4'h0, 0},
		'{0, 0, 0,             0, 0, 0,             EDGE, 0, 0,        0,    1, 0, 4'h0, 0},
		'{0, 0, 0,             0, 0, 0,             0, 0, 0,           RMAX, 1, 0, 4'h0, 0},
		'{0, 0, 0,             0, 0, 0,             CMAX, CMAX, CMAX,  0,    1, 0, 4'h0, 0},
		'{0, 0, 0,             0, 0, 0,             CMIN, CMIN, CMIN,  RMAX, 1, 0, 4'h0, 0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [fbct_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [fbct_pkg::CFG_DATA_W-1:0] cfg_data;

	fbct_in_if in_ch();
	fbct_out_if out_ch();

	frustum_box_clip_test i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [fbct_pkg::NORMAL_W-1:0] normal_copy [fbct_pkg::REG_PLANES];
	logic [2*fbct_pkg::DIST_W-1:0] dist_copy [2];
	logic [fbct_pkg::SEL_W-1:0] select_copy;

	verdict_t pending_verdicts [$];

	int cycles;
	int mismatches;
	int requests_sent;
	int results_seen;
	int clipped_seen;
	int flagged_seen;
	int settings_loaded;
	int tx_calm;
	bit tx_idling = 1'b1;
	bit rx_idling = 1'b1;
	bit long_hold_req;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("tb: mismatch at cycle %0d: %s", cycles, what);
	endtask

	// Q.14 signed distance of a point from plane p
	function automatic longint plane_side(input int p, input longint px, input longint py,
			input longint pz);
		logic signed [fbct_pkg::NORM_W-1:0] nx, ny, nz;
		logic signed [fbct_pkg::DIST_W-1:0] d;
		nx = normal_copy[p][fbct_pkg::NORM_W-1:0];
		ny = normal_copy[p][2*fbct_pkg::NORM_W-1:fbct_pkg::NORM_W];
		nz = normal_copy[p][3*fbct_pkg::NORM_W-1:2*fbct_pkg::NORM_W];
		d = p[0] ? dist_copy[p/2][2*fbct_pkg::DIST_W-1:fbct_pkg::DIST_W]
			: dist_copy[p/2][fbct_pkg::DIST_W-1:0];
		return longint'(nx) * px + longint'(ny) * py + longint'(nz) * pz
			- (longint'(d) <<< fbct_pkg::FRAC_SHIFT);
	endfunction

	function automatic verdict_t cull_bounds(input bounds_t b);
		verdict_t v;
		longint lo [3], hi [3], rej [3], acc [3];
		longint rad, s;
		logic pick;
		v = '0;
		rad = longint'(b.radius) <<< fbct_pkg::FRAC_SHIFT;
		for (int a = 0; a < 3; a++) begin
			lo[a] = longint'($signed(b.lo[a]));
			hi[a] = longint'($signed(b.hi[a]));
		end
		for (int p = 0; p < fbct_pkg::CELL_COUNT; p++) begin
			if (b.rotated) begin
				s = plane_side(p, $signed(b.ctr[0]), $signed(b.ctr[1]), $signed(b.ctr[2]));
				if (s <= -rad) begin
					v.flags = '0;
					v.clipped = 1'b1;
					return v;
				end
				if (s <= rad)
					v.flags[p] = 1'b1;
			end else begin
				for (int a = 0; a < 3; a++) begin
					pick = select_copy[3*p+a];
					rej[a] = pick ? hi[a] : lo[a];
					acc[a] = pick ? lo[a] : hi[a];
				end
				// first plane that rejects ends the test and drops earlier flags
				if (plane_side(p, rej[0], rej[1], rej[2]) <= 0) begin
					v.flags = '0;
					v.clipped = 1'b1;
					return v;
				end
				if (plane_side(p, acc[0], acc[1], acc[2]) <= 0)
					v.flags[p] = 1'b1;
			end
		end
		return v;
	endfunction

	function automatic logic [fbct_pkg::COORD_W-1:0] clamp_coord(input int v);
		if (v > CMAX)
			return fbct_pkg::COORD_W'(CMAX);
		if (v < CMIN)
			return fbct_pkg::COORD_W'(CMIN);
		return fbct_pkg::COORD_W'(v);
	endfunction

	function automatic bounds_t roll_bounds();
		bounds_t b;
		int span, c, h, lo, hi;
		if ($urandom_range(0, 7) == 0) begin
			for (int a = 0; a < 3; a++) begin
				b.lo[a] = fbct_pkg::COORD_W'($urandom);
				b.hi[a] = fbct_pkg::COORD_W'($urandom);
				b.ctr[a] = fbct_pkg::COORD_W'($urandom);
			end
			b.radius = fbct_pkg::RAD_W'($urandom);
			b.rotated = 1'($urandom);
			return b;
		end
		case ($urandom_range(0, 3)) inside
			0: span = 2000;
			1, 2: span = 24000;
			default: span = CMAX;
		endcase
		for (int a = 0; a < 3; a++) begin
			c = int'($urandom_range(0, 2 * span)) - span;
			h = $urandom_range(0, span / 3);
			lo = c - h;
			hi = c + h;
			if ($urandom_range(0, 15) == 0)
				{lo, hi} = {hi, lo};
			b.lo[a] = clamp_coord(lo);
			b.hi[a] = clamp_coord(hi);
			b.ctr[a] = fbct_pkg::COORD_W'(c);
		end
		case ($urandom_range(0, 15))
			0: b.radius = '0;
			1: b.radius = '1;
			default: b.radius = fbct_pkg::RAD_W'($urandom_range(0, span / 2));
		endcase
		b.rotated = 1'($urandom_range(0, 1));
		return b;
	endfunction

	// unit normals +x, -x, +y, -y, every plane 16000 units out
	function automatic reg_set_t axis_frustum();
		reg_set_t s;
		s = '0;
		s[fbct_pkg::REG_PLANE0_NORMAL] = {16'h0, 16'h0, 16'h0, 16'h4000};
		s[fbct_pkg::REG_PLANE1_NORMAL] = {16'h0, 16'h0, 16'h0, 16'hC000};
		s[fbct_pkg::REG_PLANE2_NORMAL] = {16'h0, 16'h0, 16'h4000, 16'h0};
		s[fbct_pkg::REG_PLANE3_NORMAL] = {16'h0, 16'h0, 16'hC000, 16'h0};
		s[fbct_pkg::REG_DIST_LOW_PAIR] = {2{32'(EDGE)}};
		s[fbct_pkg::REG_DIST_HIGH_PAIR] = {2{32'(EDGE)}};
		// reject on max x for plane 1, max y for plane 3
		s[fbct_pkg::REG_CORNER_SELECT] = 64'b0100_0000_1000;
		return s;
	endfunction

	function automatic reg_set_t rolled_frustum(input roll_mode_t mode);
		reg_set_t s;
		int n [3];
		logic [fbct_pkg::SEL_W-1:0] sel;
		sel = '0;
		for (int p = 0; p < fbct_pkg::REG_PLANES; p++) begin
			for (int a = 0; a < 3; a++) begin
				n[a] = int'($urandom_range(0, 32768)) - 16384;
				sel[3*p+a] = (n[a] < 0);
			end
			s[int'(fbct_pkg::REG_PLANE0_NORMAL) + p] =
				{16'($urandom), 16'(n[2]), 16'(n[1]), 16'(n[0])};
		end
		s[fbct_pkg::REG_DIST_LOW_PAIR] = {32'(int'($urandom_range(0, 40000)) - 20000),
			32'(int'($urandom_range(0, 40000)) - 20000)};
		s[fbct_pkg::REG_DIST_HIGH_PAIR] = {32'(int'($urandom_range(0, 40000)) - 20000),
			32'(int'($urandom_range(0, 40000)) - 20000)};
		s[fbct_pkg::REG_CORNER_SELECT] = {52'($urandom),
			mode == SET_SKEWED ? fbct_pkg::SEL_W'($urandom) : sel};
		if (mode == SET_NOISE)
			for (int r = 0; r <= int'(fbct_pkg::REG_CORNER_SELECT); r++)
				s[r] = {$urandom, $urandom};
		return s;
	endfunction

	function automatic reg_set_t corner_extreme(input bit upper);
		reg_set_t s;
		for (int p = 0; p < fbct_pkg::REG_PLANES; p++)
			s[int'(fbct_pkg::REG_PLANE0_NORMAL) + p] = upper ? {16'h0, {3{16'h7FFF}}}
				: {16'hFFFF, {3{16'h8000}}};
		s[fbct_pkg::REG_DIST_LOW_PAIR] = upper ? {2{32'h7FFF_FFFF}} : {2{32'h8000_0000}};
		s[fbct_pkg::REG_DIST_HIGH_PAIR] = upper ? {2{32'h7FFF_FFFF}} : {2{32'h8000_0000}};
		s[fbct_pkg::REG_CORNER_SELECT] = upper ? 64'hFFF : 64'h0;
		return s;
	endfunction

	task automatic load_setting(input reg_set_t s);
		for (int r = 0; r <= int'(fbct_pkg::REG_CORNER_SELECT); r++) begin
			@(negedge clk);
			cfg_we = 1'b1;
			cfg_idx = fbct_pkg::CFG_IDX_W'(r);
			cfg_data = s[r];
			@(posedge clk);
			case (fbct_pkg::CFG_IDX_W'(r)) inside
				fbct_pkg::REG_PLANE0_NORMAL, fbct_pkg::REG_PLANE1_NORMAL,
				fbct_pkg::REG_PLANE2_NORMAL, fbct_pkg::REG_PLANE3_NORMAL:
					normal_copy[r - int'(fbct_pkg::REG_PLANE0_NORMAL)] =
						s[r][fbct_pkg::NORMAL_W-1:0];
				fbct_pkg::REG_DIST_LOW_PAIR: dist_copy[0] = s[r];
				fbct_pkg::REG_DIST_HIGH_PAIR: dist_copy[1] = s[r];
				fbct_pkg::REG_CORNER_SELECT: select_copy = s[r][fbct_pkg::SEL_W-1:0];
				default: ;
			endcase
		end
		@(negedge clk);
		cfg_we = 1'b0;
		settings_loaded++;
	endtask

	task automatic offer_box(input bounds_t b, input bit known, input verdict_t want);
		int gap;
		gap = 0;
		if (tx_idling) begin
			if (tx_calm > 0)
				tx_calm--;
			else if ($urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 13);
				tx_calm = $urandom_range(0, 30);
			end
		end
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.box_min_x = b.lo[0];
		in_ch.box_min_y = b.lo[1];
		in_ch.box_min_z = b.lo[2];
		in_ch.box_max_x = b.hi[0];
		in_ch.box_max_y = b.hi[1];
		in_ch.box_max_z = b.hi[2];
		in_ch.center_x = b.ctr[0];
		in_ch.center_y = b.ctr[1];
		in_ch.center_z = b.ctr[2];
		in_ch.bound_radius = b.radius;
		in_ch.rotated = b.rotated;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		pending_verdicts.push_back(known ? want : cull_bounds(b));
		requests_sent++;
	endtask

	// drop valid, wait out every pending result, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input reg_set_t s, input int count, input bit squeeze);
		settle();
		load_setting(s);
		for (int i = 0; i < count; i++) begin
			if (squeeze && i == count / 4)
				long_hold_req = 1'b1;
			offer_box(roll_bounds(), 1'b0, '0);
		end
	endtask

	initial begin : result_drain
		int stall_left, run_left;
		stall_left = 0;
		run_left = 0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (rx_idling && stall_left == 0 && run_left == 0) begin
				stall_left = $urandom_range(1, 13);
				run_left = $urandom_range(0, 30);
			end
			out_ch.ready = (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
			else if (run_left > 0)
				run_left--;
		end
	end

	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				flag_mismatch("result with no request outstanding");
			end else begin
				want = pending_verdicts.pop_front();
				results_seen++;
				if (want.clipped)
					clipped_seen++;
				if (want.flags != '0)
					flagged_seen++;
				if (out_ch.clip_flags !== want.flags)
					flag_mismatch($sformatf("clip_flags %h, want %h", out_ch.clip_flags,
						want.flags));
				if (out_ch.fully_clipped !== want.clipped)
					flag_mismatch($sformatf("fully_clipped %b, want %b", out_ch.fully_clipped,
						want.clipped));
			end
		end
	end

	initial begin : stimulus
		bounds_t b;
		verdict_t want;
		dir_row_t row;
		bit axis_loaded;
		axis_loaded = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.box_min_x = '0;
		in_ch.box_min_y = '0;
		in_ch.box_min_z = '0;
		in_ch.box_max_x = '0;
		in_ch.box_max_y = '0;
		in_ch.box_max_z = '0;
		in_ch.center_x = '0;
		in_ch.center_y = '0;
		in_ch.center_z = '0;
		in_ch.bound_radius = '0;
		in_ch.rotated = 1'b0;
		for (int p = 0; p < fbct_pkg::REG_PLANES; p++)
			normal_copy[p] = '0;
		dist_copy[0] = '0;
		dist_copy[1] = '0;
		select_copy = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_COUNT; i++) begin
			row = dir_rows[i];
			if (!row.known && !axis_loaded) begin
				settle();
				load_setting(axis_frustum());
				axis_loaded = 1'b1;
			end
			b.lo = {fbct_pkg::COORD_W'(row.lo_z), fbct_pkg::COORD_W'(row.lo_y),
				fbct_pkg::COORD_W'(row.lo_x)};
			b.hi = {fbct_pkg::COORD_W'(row.hi_z), fbct_pkg::COORD_W'(row.hi_y),
				fbct_pkg::COORD_W'(row.hi_x)};
			b.ctr = {fbct_pkg::COORD_W'(row.c_z), fbct_pkg::COORD_W'(row.c_y),
				fbct_pkg::COORD_W'(row.c_x)};
			b.radius = fbct_pkg::RAD_W'(row.radius);
			b.rotated = row.rotated;
			want.flags = row.flags;
			want.clipped = row.clipped;
			offer_box(b, row.known, want);
		end

		run_phase(axis_frustum(), 100, 1'b0);
		run_phase(rolled_frustum(SET_MATCHED), 110, 1'b1);
		run_phase(rolled_frustum(SET_SKEWED), 100, 1'b0);
		run_phase(corner_extreme(1'b1), 60, 1'b0);
		run_phase(corner_extreme(1'b0), 60, 1'b0);
		run_phase(rolled_frustum(SET_NOISE), 100, 1'b0);
		run_phase(rolled_frustum(SET_MATCHED), 60, 1'b1);
		// steady stream to close out
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		run_phase(rolled_frustum(SET_MATCHED), 100, 1'b0);
		settle();

		$display("tb: %0d box and sphere requests over %0d plane settings", requests_sent,
			settings_loaded);
		$display("tb: %0d results checked, %0d fully clipped, %0d with plane flags",
			results_seen, clipped_seen, flagged_seen);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
